>>> src/spqa_pkg.sv
// Shared types, codes and defaults for the sorted priority queue with aging.
package spqa_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TOP_PRIORITY_DEF = 15;
  localparam int ID_BITS_DEF      = 10;
  localparam int PRIO_W           = 4;
  localparam int STATUS_W         = 2;

  localparam logic ACT_INSERT   = 1'b0;
  localparam logic ACT_RETRIEVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_PRIO = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_START,
    OP_INS_STEP,
    OP_INS_PLACE,
    OP_RET_START,
    OP_RET_HEAD,
    OP_AGE_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } spqa_cmd_t;

  typedef struct packed {
    logic reject;
    logic retrieve;
    logic empty;
    logic stop;
    logic last;
    logic one_left;
  } spqa_stat_t;

endpackage

>>> src/sorted_priority_queue_aging.sv
// Top level of the sorted priority queue with aging.
//
//  channel   handshake          ports
//  --------  -----------------  ---------------------------------------------
//  command   start_i / busy_o   action_i, entry_id_i, entry_priority_i
//  result    done_o (strobe)    head_id_o, status_o, occupancy_o
//
// A transaction is taken when start_i is high and busy_o is low; busy_o stays
// high until the result strobe has been shown, so one transaction runs at a time.
// A rejected item or an insert into an empty queue goes straight to the result; any
// other insert first walks past the entries of greater priority, and a retrieve
// ages the entries left;
// the walk and the aging pass visit one slot per cycle through the slot RAM port.
// Reset clears the controller state, pointers and count only; the slot RAM is not cleared.
// The strobe lasts one cycle and is not held off by the receiver.
module sorted_priority_queue_aging import spqa_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int TOP_PRIORITY = TOP_PRIORITY_DEF,
  parameter int ID_BITS      = ID_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             action_i,
  input  logic [ID_BITS-1:0]               entry_id_i,
  input  logic [PRIO_W-1:0]                entry_priority_i,
  output logic                             done_o,
  output logic [ID_BITS-1:0]               head_id_o,
  output logic [STATUS_W-1:0]              status_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy_o
);

  spqa_cmd_t  cmd;
  spqa_stat_t stat;
  logic       ctrl_busy;

  spqa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (ctrl_busy),
    .done_o (done_o)
  );

  spqa_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TOP_PRIORITY(TOP_PRIORITY),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (action_i),
    .entry_id_i      (entry_id_i),
    .entry_priority_i(entry_priority_i),
    .head_id_o       (head_id_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

  assign busy_o = ctrl_busy;

endmodule

>>> src/spqa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/spqa_dp.sv
// Datapath: ring pointers, slot memory, sorted-insert walk and aging pass.
module spqa_dp import spqa_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int TOP_PRIORITY = TOP_PRIORITY_DEF,
  parameter int ID_BITS      = ID_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  spqa_cmd_t                          cmd_i,
  output spqa_stat_t                         stat_o,
  input  logic                               action_i,
  input  logic [ID_BITS-1:0]                 entry_id_i,
  input  logic [PRIO_W-1:0]                  entry_priority_i,
  output logic [ID_BITS-1:0]                 head_id_o,
  output logic [STATUS_W-1:0]                status_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = ID_BITS + PRIO_W;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
    return r;
  endfunction

  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      tail_q, tail_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      walked_q, walked_d;
  logic               act_q, act_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [PRIO_W-1:0]  prio_q, prio_d;
  status_e            status_q, status_d;
  logic [ID_BITS-1:0] head_id_q, head_id_d;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [DW-1:0]      wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [DW-1:0]      rdata;
  logic [ID_BITS-1:0] rd_id;
  logic [PRIO_W-1:0]  rd_prio;
  logic [PRIO_W-1:0]  aged_prio;
  status_e            check_status;

  spqa_ram #(
    .WIDTH(DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_id     = rdata[DW-1:PRIO_W];
  assign rd_prio   = rdata[PRIO_W-1:0];
  assign aged_prio = (rd_prio > PRIO_W'(1)) ? rd_prio - PRIO_W'(1) : rd_prio;

  always_comb begin
    if (action_i == ACT_INSERT) begin
      if (entry_priority_i == '0 || int'(entry_priority_i) > TOP_PRIORITY) begin
        check_status = ST_BAD_PRIO;
      end else if (count_q == CW'(QUEUE_DEPTH)) begin
        check_status = ST_FULL;
      end else begin
        check_status = ST_OK;
      end
    end else if (count_q == '0) begin
      check_status = ST_EMPTY;
    end else begin
      check_status = ST_OK;
    end
  end

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    pos_d     = pos_q;
    walked_d  = walked_q;
    act_d     = act_q;
    id_d      = id_q;
    prio_d    = prio_q;
    status_d  = status_q;
    head_id_d = head_id_q;
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = rdata;
    re        = 1'b0;
    raddr     = head_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        act_d     = action_i;
        id_d      = entry_id_i;
        prio_d    = entry_priority_i;
        status_d  = check_status;
        head_id_d = '0;
        pos_d     = tail_q;
        walked_d  = '0;
      end
      OP_INS_START: begin
        re    = 1'b1;
        raddr = ring_prev(pos_q);
      end
      OP_INS_STEP: begin
        we       = 1'b1;
        wdata    = rdata;
        re       = 1'b1;
        raddr    = ring_prev(ring_prev(pos_q));
        pos_d    = ring_prev(pos_q);
        walked_d = walked_q + CW'(1);
      end
      OP_INS_PLACE: begin
        we      = 1'b1;
        wdata   = {id_q, prio_q};
        tail_d  = ring_next(tail_q);
        count_d = count_q + CW'(1);
      end
      OP_RET_START: begin
        re    = 1'b1;
        raddr = head_q;
      end
      OP_RET_HEAD: begin
        head_id_d = rd_id;
        head_d    = ring_next(head_q);
        count_d   = count_q - CW'(1);
        pos_d     = ring_next(head_q);
        walked_d  = '0;
        re        = 1'b1;
        raddr     = ring_next(head_q);
      end
      OP_AGE_STEP: begin
        we       = 1'b1;
        wdata    = {rd_id, aged_prio};
        re       = 1'b1;
        raddr    = ring_next(pos_q);
        pos_d    = ring_next(pos_q);
        walked_d = walked_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    walked_q  <= walked_d;
    act_q     <= act_d;
    id_q      <= id_d;
    prio_q    <= prio_d;
    status_q  <= status_d;
    head_id_q <= head_id_d;
  end

  assign stat_o.reject   = (status_q != ST_OK);
  assign stat_o.retrieve = (act_q == ACT_RETRIEVE);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.stop     = (rd_prio <= prio_q);
  assign stat_o.last     = ((walked_q + CW'(1)) == count_q);
  assign stat_o.one_left = (count_q == CW'(1));

  assign head_id_o   = head_id_q;
  assign status_o    = status_q;
  assign occupancy_o = count_q;

endmodule

>>> src/spqa_ctrl.sv
// Controller: sequences the check, insert walk, retrieve and aging pass.
module spqa_ctrl import spqa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  spqa_stat_t stat_i,
  output spqa_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_CHECK     = 7'b0000010,
    S_INS_WALK  = 7'b0000100,
    S_INS_PLACE = 7'b0001000,
    S_RET_HEAD  = 7'b0010000,
    S_AGE       = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.reject) begin
          state_d = S_RESP;
        end else if (stat_i.retrieve) begin
          cmd_o.op = OP_RET_START;
          state_d  = S_RET_HEAD;
        end else if (stat_i.empty) begin
          cmd_o.op = OP_INS_PLACE;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = OP_INS_START;
          state_d  = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        if (stat_i.stop) begin
          cmd_o.op = OP_INS_PLACE;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = OP_INS_STEP;
          if (stat_i.last) begin
            state_d = S_INS_PLACE;
          end
        end
      end
      S_INS_PLACE: begin
        cmd_o.op = OP_INS_PLACE;
        state_d  = S_RESP;
      end
      S_RET_HEAD: begin
        cmd_o.op = OP_RET_HEAD;
        state_d  = stat_i.one_left ? S_RESP : S_AGE;
      end
      S_AGE: begin
        cmd_o.op = OP_AGE_STEP;
        if (stat_i.last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

>>> src/spqa_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spqa_port_checks import spqa_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic [ID_BITS-1:0]               head_id_o,
  input logic [STATUS_W-1:0]              status_o,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after an accepted transaction");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside a transaction");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_reject_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> head_id_o == '0)
    else $error("nonzero id on a rejected transaction");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> occupancy_o <= CW'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

endmodule

bind sorted_priority_queue_aging spqa_port_checks #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .ID_BITS    (ID_BITS)
) u_checker (.*);

>>> tb/spqa_checker.sv
// Checker that predicts and compares every result of the sorted priority queue with aging.
module spqa_checker import spqa_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int TOP_PRIORITY = TOP_PRIORITY_DEF,
  parameter int ID_BITS      = ID_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic                             action_i,
  input  logic [ID_BITS-1:0]               entry_id_i,
  input  logic [PRIO_W-1:0]                entry_priority_i,
  input  logic                             done_i,
  input  logic [ID_BITS-1:0]               head_id_i,
  input  logic [STATUS_W-1:0]              status_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               full_seen_o,
  output int                               empty_seen_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct {
    logic [ID_BITS-1:0] head_id;
    status_e            status;
    logic [OCC_W-1:0]   occupancy;
  } queue_outcome_t;

  logic [ID_BITS-1:0] ring_id[QUEUE_DEPTH];
  logic [PRIO_W-1:0]  ring_prio[QUEUE_DEPTH];
  int                 head_pos;
  int                 tail_pos;
  int                 held_count;

  queue_outcome_t     outcome_q[$];
  queue_outcome_t     oldest;
  int                 fails;
  int                 full_seen;
  int                 empty_seen;

  function automatic queue_outcome_t serve_transaction(logic act, logic [ID_BITS-1:0] id,
                                                       logic [PRIO_W-1:0] prio);
    queue_outcome_t res;
    int             pos;
    int             walked;
    res.head_id = '0;
    res.status  = ST_OK;
    if (act == ACT_INSERT) begin
      if (prio < 1 || prio > TOP_PRIORITY) begin
        res.status = ST_BAD_PRIO;
      end else if (held_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos    = tail_pos;
        walked = 0;
        // shift greater priorities one slot back
        while (walked < held_count &&
               ring_prio[(pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH] > prio) begin
          ring_id[pos]   = ring_id[(pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
          ring_prio[pos] = ring_prio[(pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
          pos            = (pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          walked++;
        end
        ring_id[pos]   = id;
        ring_prio[pos] = prio;
        tail_pos       = (tail_pos + 1) % QUEUE_DEPTH;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.head_id = ring_id[head_pos];
        head_pos    = (head_pos + 1) % QUEUE_DEPTH;
        held_count--;
        // age the remaining entries
        pos = head_pos;
        for (int k = 0; k < held_count; k++) begin
          if (ring_prio[pos] > 1) begin
            ring_prio[pos] = ring_prio[pos] - 1'b1;
          end
          pos = (pos + 1) % QUEUE_DEPTH;
        end
      end
    end
    res.occupancy = held_count[OCC_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_pos     = 0;
      tail_pos     = 0;
      held_count   = 0;
      fails        = 0;
      full_seen    = 0;
      empty_seen   = 0;
      outcome_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      full_seen_o  <= 0;
      empty_seen_o <= 0;
    end else begin
      if (done_i) begin
        if (status_i == ST_FULL) full_seen++;
        if (status_i == ST_EMPTY) empty_seen++;
        if (outcome_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fails++;
        end else begin
          oldest = outcome_q.pop_front();
          if (head_id_i !== oldest.head_id) begin
            $error("head_id: expected %0d, actual %0d", oldest.head_id, head_id_i);
            fails++;
          end
          if (status_i !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, status_i);
            fails++;
          end
          if (occupancy_i !== oldest.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", oldest.occupancy, occupancy_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        outcome_q.push_back(serve_transaction(action_i, entry_id_i, entry_priority_i));
      end
      fail_count_o <= fails;
      pending_o    <= outcome_q.size();
      full_seen_o  <= full_seen;
      empty_seen_o <= empty_seen;
    end
  end

endmodule

>>> tb/sorted_priority_queue_aging_test.sv
// Top of the testbench: clock, reset, stimulus and verdict for the priority queue.
module sorted_priority_queue_aging_test;
  import spqa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH    = QUEUE_DEPTH_DEF;
  localparam int TOP_PRIORITY   = TOP_PRIORITY_DEF;
  localparam int ID_BITS        = ID_BITS_DEF;
  localparam int OCC_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int ITEMS_PER_PASS = 150;
  localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 8;
  localparam int CYCLE_LIMIT    = 200000;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               start_i          = 1'b0;
  logic               action_i         = ACT_INSERT;
  logic [ID_BITS-1:0] entry_id_i       = '0;
  logic [PRIO_W-1:0]  entry_priority_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [ID_BITS-1:0] head_id_o;
  logic [STATUS_W-1:0] status_o;
  logic [OCC_W-1:0]   occupancy_o;

  int fail_count;
  int pending;
  int full_seen;
  int empty_seen;
  int cycle_count = 0;
  int idle_pct    = 0;
  int insert_count;
  int retrieve_count;
  int zero_prio_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_priority_queue_aging #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TOP_PRIORITY(TOP_PRIORITY),
    .ID_BITS     (ID_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .action_i        (action_i),
    .entry_id_i      (entry_id_i),
    .entry_priority_i(entry_priority_i),
    .done_o          (done_o),
    .head_id_o       (head_id_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

  spqa_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TOP_PRIORITY(TOP_PRIORITY),
    .ID_BITS     (ID_BITS)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .action_i        (action_i),
    .entry_id_i      (entry_id_i),
    .entry_priority_i(entry_priority_i),
    .done_i          (done_o),
    .head_id_i       (head_id_o),
    .status_i        (status_o),
    .occupancy_i     (occupancy_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .full_seen_o     (full_seen),
    .empty_seen_o    (empty_seen)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached", CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [ID_BITS-1:0] id, logic [PRIO_W-1:0] prio);
    while ($urandom_range(99) < idle_pct) begin
      start_i          <= 1'b0;
      action_i         <= 1'($urandom);
      entry_id_i       <= ID_BITS'($urandom);
      entry_priority_i <= PRIO_W'($urandom);
      @(posedge clk_i);
    end
    start_i          <= 1'b1;
    action_i         <= act;
    entry_id_i       <= id;
    entry_priority_i <= prio;
    if (act == ACT_INSERT) begin
      insert_count++;
      if (prio == 0) zero_prio_count++;
    end else begin
      retrieve_count++;
    end
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_item(int insert_pct);
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      send_item(ACT_INSERT, ID_BITS'($urandom), '0);
    end else if (r < insert_pct) begin
      send_item(ACT_INSERT, ID_BITS'($urandom), PRIO_W'($urandom_range(TOP_PRIORITY, 1)));
    end else begin
      send_item(ACT_RETRIEVE, ID_BITS'($urandom), PRIO_W'($urandom));
    end
  endtask

  initial begin
    int pass_idle[3];
    int insert_pct;
    pass_idle = '{20, 69, 0};
    insert_pct      = 50;
    insert_count    = 0;
    retrieve_count  = 0;
    zero_prio_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_RETRIEVE, '0, '0);
    send_item(ACT_INSERT, '1, '0);
    send_item(ACT_INSERT, '0, PRIO_W'(TOP_PRIORITY));
    send_item(ACT_INSERT, '1, PRIO_W'(1));
    send_item(ACT_INSERT, ID_BITS'('h155), PRIO_W'(8));
    send_item(ACT_INSERT, ID_BITS'('h2AA), PRIO_W'(8));
    send_item(ACT_RETRIEVE, '0, '1);
    send_item(ACT_RETRIEVE, '1, '0);
    repeat (QUEUE_DEPTH - 2) begin
      send_item(ACT_INSERT, ID_BITS'($urandom), PRIO_W'($urandom_range(TOP_PRIORITY, 1)));
    end
    send_item(ACT_INSERT, '1, PRIO_W'(TOP_PRIORITY));
    send_item(ACT_INSERT, '0, '0);
    send_item(ACT_RETRIEVE, '0, '0);
    wait_all_results();

    for (int p = 0; p < 3; p++) begin
      idle_pct = pass_idle[p];
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 52;
            default: insert_pct = 20;
          endcase
        end
        if (p == 0 && n == ITEMS_PER_PASS / 2) begin
          wait_all_results();
        end
        random_item(insert_pct);
      end
      wait_all_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("ran %0d inserts (%0d with zero priority) and %0d retrieves",
             insert_count, zero_prio_count, retrieve_count);
    $display("saw %0d full rejections and %0d empty rejections over three idle profiles",
             full_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
